/* hw/rtl/rcp_pkg.sv */
// Shared types and constants of the replica-aware chunk placer.
`default_nettype none

package rcp_pkg;

	localparam int NODE_W        = 7;
	localparam int HOST_W        = 6;
	localparam int SIZE_W        = 32;
	localparam int SEQ_W         = 32;
	localparam int LOAD_W        = 32;
	localparam int TOTAL_W       = 48;
	localparam int SLOT_OUT_W    = 3;
	localparam int SLOTS_CFG_W   = 4;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 32;
	localparam int DEF_MAX_NODES = 64;
	localparam int DEF_MAX_SLOTS = 8;
	localparam int Q_DEPTH       = 2;
	localparam int Q_PTR_W       = $clog2(Q_DEPTH);

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_NODES    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOTS        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STATIC_COUNT = 2'd2;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
	localparam logic [LOAD_W-1:0]  LOAD_MAX  = {LOAD_W{1'b1}};
	localparam logic [SEQ_W-1:0]   SEQ_MAX   = {SEQ_W{1'b1}};

	typedef struct packed {
		logic                   bad;
		logic                   single;
		logic [2:0][NODE_W-1:0] rep;
		logic [SIZE_W-1:0]      size;
		logic [SEQ_W-1:0]       seq;
	} rcp_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/rcp_ram.sv */
// Generic simple dual-port RAM with a registered read port.
`default_nettype none

module rcp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/rcp_queue.sv */
// Short command queue between the classifying front end and the placement engine.
`default_nettype none

module rcp_queue import rcp_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire rcp_cmd_t push_cmd,
	input  wire logic     pop,
	output logic          full,
	output logic          empty,
	output rcp_cmd_t      head
);

	rcp_cmd_t           entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wptr_q;
	logic [Q_PTR_W-1:0] rptr_q;
	logic [Q_PTR_W:0]   count_q;

	assign full  = (count_q == (Q_PTR_W + 1)'(Q_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/rcp_front.sv */
// Front end: accepts chunks, numbers them and works out their replica set.
`default_nettype none

module rcp_front import rcp_pkg::*; #(
	parameter int MAX_NODES = DEF_MAX_NODES
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [HOST_W-1:0]      host_node,
	input  wire logic [SIZE_W-1:0]      chunk_size,
	input  wire logic [NODE_W-1:0]      num_nodes,
	input  wire logic [CFG_DATA_W-1:0]  static_count,
	input  wire logic                   q_full,
	input  wire logic                   clearing,
	output logic                        push,
	output rcp_cmd_t                    push_cmd
);

	localparam int ENW = ($clog2(MAX_NODES + 1) > NODE_W) ? $clog2(MAX_NODES + 1) : NODE_W;

	logic [SEQ_W-1:0]  chunk_cnt_q;
	logic [NODE_W-1:0] eff_nodes;
	logic [NODE_W-1:0] host_ext;
	logic [NODE_W:0]   host_inc;

	assign in_stall = q_full || clearing;
	assign push     = in_valid && !in_stall;

	always_comb begin
		eff_nodes = (ENW'(num_nodes) > ENW'(MAX_NODES)) ? NODE_W'(MAX_NODES) : num_nodes;
		host_ext  = NODE_W'(host_node);
		host_inc  = {1'b0, host_ext} + 1'b1;

		push_cmd.bad    = (host_ext >= eff_nodes);
		push_cmd.single = (chunk_cnt_q < static_count);
		push_cmd.rep[0] = (host_ext == '0) ? (eff_nodes - 1'b1) : (host_ext - 1'b1);
		push_cmd.rep[1] = host_ext;
		push_cmd.rep[2] = (host_inc >= {1'b0, eff_nodes}) ? '0 : host_inc[NODE_W-1:0];
		push_cmd.size   = chunk_size;
		push_cmd.seq    = chunk_cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_cnt_q <= '0;
		end else if (push && (chunk_cnt_q != SEQ_MAX)) begin
			chunk_cnt_q <= chunk_cnt_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/rcp_back.sv */
// Placement engine: picks slots, updates node counters and slot totals, drives results.
`default_nettype none

module rcp_back import rcp_pkg::*; #(
	parameter int MAX_NODES = DEF_MAX_NODES,
	parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [SLOTS_CFG_W-1:0] slots_per_node,
	input  wire logic                   q_empty,
	input  wire rcp_cmd_t               q_head,
	output logic                        q_pop,
	output logic                        clearing,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [HOST_W-1:0]           out_target,
	output logic [SLOT_OUT_W-1:0]       out_slot,
	output logic [TOTAL_W-1:0]          out_total,
	output logic [SEQ_W-1:0]            out_seq,
	output logic                        out_bad,
	output logic                        out_last
);

	localparam int NA  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int SPW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int SD  = MAX_NODES * MAX_SLOTS;
	localparam int SA  = (SD > 1) ? $clog2(SD) : 1;
	localparam int ESW = ($clog2(MAX_SLOTS + 1) > SLOTS_CFG_W) ?
		$clog2(MAX_SLOTS + 1) : SLOTS_CFG_W;
	localparam int NWW = LOAD_W + SPW;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LD1,
		ST_LD2,
		ST_LD3,
		ST_NODE,
		ST_SLOT,
		ST_BAD
	} state_t;

	state_t            state_q;
	rcp_cmd_t          cmd_q;
	logic [1:0]        rep_idx_q;
	logic [NODE_W-1:0] cur_node_q;
	logic              use_reg_q;
	logic [NWW-1:0]    node_word_q;
	logic [NWW-1:0]    node_new_q;
	logic [SPW-1:0]    p_q;
	logic [SA-1:0]     slot_addr_q;
	logic [SA-1:0]     clr_cnt_q;

	logic                  out_valid_q;
	logic [HOST_W-1:0]     out_target_q;
	logic [SLOT_OUT_W-1:0] out_slot_q;
	logic [TOTAL_W-1:0]    out_total_q;
	logic [SEQ_W-1:0]      out_seq_q;
	logic                  out_bad_q;
	logic                  out_last_q;

	logic               node_we;
	logic [NA-1:0]      node_waddr;
	logic [NWW-1:0]     node_wdata;
	logic               node_re;
	logic [NA-1:0]      node_raddr;
	logic [NWW-1:0]     node_rdata;
	logic               slot_we;
	logic [SA-1:0]      slot_waddr;
	logic [TOTAL_W-1:0] slot_wdata;
	logic               slot_re;
	logic [SA-1:0]      slot_raddr;
	logic [TOTAL_W-1:0] slot_rdata;

	logic [ESW-1:0]     eff_slots;
	logic               out_free;
	logic [NWW-1:0]     node_word;
	logic [LOAD_W-1:0]  cur_load;
	logic [SPW-1:0]     cur_ptr;
	logic [SPW-1:0]     p;
	logic [ESW-1:0]     p_inc;
	logic [SPW-1:0]     next_ptr;
	logic [LOAD_W-1:0]  new_load;
	logic [SA-1:0]      slot_addr;
	logic [TOTAL_W:0]   sum;
	logic [TOTAL_W-1:0] new_total;
	logic               last_place;
	logic [NODE_W-1:0]  next_node;
	logic [LOAD_W-1:0]  rd_load;
	logic [LOAD_W-1:0]  best_load;
	logic               rd_better;

	rcp_ram #(
		.WIDTH (NWW),
		.DEPTH (MAX_NODES)
	) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.re    (node_re),
		.raddr (node_raddr),
		.rdata (node_rdata)
	);

	rcp_ram #(
		.WIDTH (TOTAL_W),
		.DEPTH (SD)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.re    (slot_re),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	assign clearing   = (state_q == ST_CLEAR);
	assign out_valid  = out_valid_q;
	assign out_target = out_target_q;
	assign out_slot   = out_slot_q;
	assign out_total  = out_total_q;
	assign out_seq    = out_seq_q;
	assign out_bad    = out_bad_q;
	assign out_last   = out_last_q;

	always_comb begin
		if (slots_per_node == '0) begin
			eff_slots = ESW'(1);
		end else if (ESW'(slots_per_node) > ESW'(MAX_SLOTS)) begin
			eff_slots = ESW'(MAX_SLOTS);
		end else begin
			eff_slots = ESW'(slots_per_node);
		end

		out_free = !out_valid_q || !out_stall;

		node_word = use_reg_q ? node_word_q : node_rdata;
		cur_load  = node_word[NWW-1:SPW];
		cur_ptr   = node_word[SPW-1:0];
		p         = (ESW'(cur_ptr) >= eff_slots) ? '0 : cur_ptr;
		p_inc     = ESW'(p) + 1'b1;
		next_ptr  = (p_inc >= eff_slots) ? '0 : SPW'(p_inc);
		new_load  = (cur_load == LOAD_MAX) ? cur_load : (cur_load + 1'b1);
		slot_addr = SA'(int'(cur_node_q) * MAX_SLOTS + int'(p));

		sum       = {1'b0, slot_rdata} + (TOTAL_W + 1)'(cmd_q.size);
		new_total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

		last_place = cmd_q.single || (rep_idx_q == 2'd2);
		next_node  = cmd_q.rep[rep_idx_q + 2'd1];

		rd_load   = node_rdata[NWW-1:SPW];
		best_load = node_word_q[NWW-1:SPW];
		rd_better = (rd_load < best_load);

		q_pop      = 1'b0;
		node_we    = 1'b0;
		node_waddr = NA'(cur_node_q);
		node_wdata = node_new_q;
		node_re    = 1'b0;
		node_raddr = NA'(q_head.rep[0]);
		slot_we    = 1'b0;
		slot_waddr = slot_addr_q;
		slot_wdata = new_total;
		slot_re    = 1'b0;
		slot_raddr = slot_addr;

		unique case (state_q)
			ST_CLEAR: begin
				node_we    = (32'(clr_cnt_q) < 32'(MAX_NODES));
				node_waddr = NA'(clr_cnt_q);
				node_wdata = '0;
				slot_we    = 1'b1;
				slot_waddr = clr_cnt_q;
				slot_wdata = '0;
			end
			ST_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					node_re = !q_head.bad;
				end
			end
			ST_LD1: begin
				node_re    = 1'b1;
				node_raddr = NA'(cmd_q.rep[1]);
			end
			ST_LD2: begin
				node_re    = 1'b1;
				node_raddr = NA'(cmd_q.rep[2]);
			end
			ST_LD3: begin
			end
			ST_NODE: begin
				slot_re = 1'b1;
			end
			ST_SLOT: begin
				if (out_free) begin
					slot_we = 1'b1;
					node_we = 1'b1;
					if (!last_place) begin
						node_re    = 1'b1;
						node_raddr = NA'(next_node);
					end
				end
			end
			ST_BAD: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_cnt_q    <= '0;
			cmd_q        <= '0;
			rep_idx_q    <= '0;
			cur_node_q   <= '0;
			use_reg_q    <= 1'b0;
			node_word_q  <= '0;
			node_new_q   <= '0;
			p_q          <= '0;
			slot_addr_q  <= '0;
			out_valid_q  <= 1'b0;
			out_target_q <= '0;
			out_slot_q   <= '0;
			out_total_q  <= '0;
			out_seq_q    <= '0;
			out_bad_q    <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == SA'(SD - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (!q_empty) begin
						cmd_q      <= q_head;
						rep_idx_q  <= '0;
						cur_node_q <= q_head.rep[0];
						use_reg_q  <= 1'b0;
						if (q_head.bad) begin
							state_q <= ST_BAD;
						end else if (q_head.single) begin
							state_q <= ST_LD1;
						end else begin
							state_q <= ST_NODE;
						end
					end
				end
				ST_LD1: begin
					node_word_q <= node_rdata;
					cur_node_q  <= cmd_q.rep[0];
					state_q     <= ST_LD2;
				end
				ST_LD2: begin
					if (rd_better) begin
						node_word_q <= node_rdata;
						cur_node_q  <= cmd_q.rep[1];
					end
					state_q <= ST_LD3;
				end
				ST_LD3: begin
					if (rd_better) begin
						node_word_q <= node_rdata;
						cur_node_q  <= cmd_q.rep[2];
					end
					use_reg_q <= 1'b1;
					state_q   <= ST_NODE;
				end
				ST_NODE: begin
					node_new_q  <= {new_load, next_ptr};
					p_q         <= p;
					slot_addr_q <= slot_addr;
					state_q     <= ST_SLOT;
				end
				ST_SLOT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_target_q <= HOST_W'(cur_node_q);
						out_slot_q   <= SLOT_OUT_W'(p_q);
						out_total_q  <= new_total;
						out_seq_q    <= cmd_q.seq;
						out_bad_q    <= 1'b0;
						out_last_q   <= last_place;
						if (last_place) begin
							state_q <= ST_IDLE;
						end else begin
							rep_idx_q   <= rep_idx_q + 2'd1;
							cur_node_q  <= next_node;
							use_reg_q   <= (next_node == cur_node_q);
							node_word_q <= node_new_q;
							state_q     <= ST_NODE;
						end
					end
				end
				ST_BAD: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_target_q <= '0;
						out_slot_q   <= '0;
						out_total_q  <= '0;
						out_seq_q    <= cmd_q.seq;
						out_bad_q    <= 1'b1;
						out_last_q   <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("Command popped from an empty queue.");

	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !q_pop)
		else $error("Command taken during the clearing pass.");

	a_bad_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_bad_q) |-> (out_last_q && (out_total_q == '0) &&
		(out_target_q == '0)))
		else $error("Bad-host word carries placement data.");

	a_write_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(slot_we && (state_q == ST_SLOT)) |-> node_we)
		else $error("Slot total written without its node update.");
`endif

endmodule

`default_nettype wire

/* hw/rtl/replica_aware_chunk_placer_top.sv */
// Top level of the replica-aware chunk placer: configuration registers and block wiring.
//
// Usage: each input word is one chunk (host_node, chunk_size), taken when in_valid is
// high and in_stall is low. Each result word (target_node, slot_index, slot_total,
// chunk_seq, bad_host, last) leaves when out_valid is high and out_stall is low.
// A chunk gives one word when it is among the first static_count chunks or has a
// bad host, and three words for the previous, same and next ring node otherwise;
// last marks the final word of a chunk.
// Configuration is written through cfg_valid/cfg_ready (cfg_ready is always high) with
// cfg_index and cfg_data, by the user only while the block is idle; it is not enforced.
// Timing: a front end queues up to two classified chunks. Per replica, the placement
// engine reads the node memory, then reads the slot memory and writes it back. A single
// placement first reads the loads of all three nodes and uses the least-loaded one; a
// bad host reads no memory. The engine takes a new chunk only when it is done with the
// last one.
// Reset: all counters and totals are cleared by a pass that writes one slot entry per
// cycle, MAX_NODES * MAX_SLOTS entries (512 by default); in_stall stays high then.
// When the receiver stalls, the result word holds and the engine waits at its next
// write-back while the front end keeps filling its queue.
`default_nettype none

module replica_aware_chunk_placer_top import rcp_pkg::*; #(
	parameter int MAX_NODES = DEF_MAX_NODES,
	parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [HOST_W-1:0]     host_node,
	input  wire logic [SIZE_W-1:0]     chunk_size,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [HOST_W-1:0]          target_node,
	output logic [SLOT_OUT_W-1:0]      slot_index,
	output logic [TOTAL_W-1:0]         slot_total,
	output logic [SEQ_W-1:0]           chunk_seq,
	output logic                       bad_host,
	output logic                       last
);

	logic [NODE_W-1:0]      num_nodes_q;
	logic [SLOTS_CFG_W-1:0] slots_q;
	logic [CFG_DATA_W-1:0]  static_count_q;

	logic     push;
	rcp_cmd_t push_cmd;
	logic     pop;
	logic     q_full;
	logic     q_empty;
	rcp_cmd_t q_head;
	logic     clearing;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_nodes_q    <= NODE_W'(1);
			slots_q        <= SLOTS_CFG_W'(1);
			static_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_NUM_NODES:    num_nodes_q    <= cfg_data[NODE_W-1:0];
				CFG_SLOTS:        slots_q        <= cfg_data[SLOTS_CFG_W-1:0];
				CFG_STATIC_COUNT: static_count_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	rcp_front #(
		.MAX_NODES (MAX_NODES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.host_node    (host_node),
		.chunk_size   (chunk_size),
		.num_nodes    (num_nodes_q),
		.static_count (static_count_q),
		.q_full       (q_full),
		.clearing     (clearing),
		.push         (push),
		.push_cmd     (push_cmd)
	);

	rcp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (q_head)
	);

	rcp_back #(
		.MAX_NODES (MAX_NODES),
		.MAX_SLOTS (MAX_SLOTS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.slots_per_node (slots_q),
		.q_empty        (q_empty),
		.q_head         (q_head),
		.q_pop          (pop),
		.clearing       (clearing),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_target     (target_node),
		.out_slot       (slot_index),
		.out_total      (slot_total),
		.out_seq        (chunk_seq),
		.out_bad        (bad_host),
		.out_last       (last)
	);

endmodule

`default_nettype wire
